### rtl/tmcs_pkg.sv
package tmcs_pkg;

    localparam int MAX_DIMENSION = 16384;
    localparam int MAX_LAYERS    = 2048;
    localparam int MAX_ELEMENT   = 128;

    // field widths
    localparam int DIM_W   = 15;
    localparam int LAYER_W = 12;
    localparam int ESIZE_W = 8;
    localparam int MIP_W   = 4;
    localparam int STAT_W  = 2;
    localparam int BYTES_W = 45;
    localparam int IMG_W   = 15;

    // shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 15;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [BYTES_W-1:0] BYTES_LIMIT  = '1;
    localparam logic [IMG_W-1:0]   IMAGES_LIMIT = '1;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BADARG = 2'd1;
    localparam t_status ST_MIPS   = 2'd2;

    typedef logic [MUL_A_W-1:0] t_mul_a;
    typedef logic [MUL_B_W-1:0] t_mul_b;
    typedef logic [MUL_P_W-1:0] t_prod;

    // full chain length: one more than the index of the highest set bit
    function automatic logic [MIP_W-1:0] chain_len(input logic [DIM_W-1:0] v);
        logic [MIP_W-1:0] n;
        n = MIP_W'(1);
        for (int i = 1; i < DIM_W; i++) begin
            if (v[i]) begin
                n = MIP_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### rtl/tmcs_mul.sv
module tmcs_mul (
    input  logic             i_clk,
    input  tmcs_pkg::t_mul_a i_a,
    input  tmcs_pkg::t_mul_b i_b,
    output tmcs_pkg::t_prod  o_prod
);
    import tmcs_pkg::*;

    t_prod r_prod;

    // one registered product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/texture_mip_chain_size_top.sv
// texture mip chain byte size
//
// input channel: one texture description per item (i_in_valid / o_in_stall).
// the item is taken when i_in_valid is high and o_in_stall is low. the block
// raises o_in_stall from taking an item until its sequencer is back in idle.
// output channel: one result item per input item (o_out_valid / i_out_stall),
// held in an output register, so a new item is taken while a result waits.
// a rejected item goes from idle to the done state and from there into the output
// register. a valid one takes, for each mip level, three passes through the one
// shared 33x15 multiplier (row pitch, slice pitch, slice count) and one accumulate
// step before it reaches the done state. the block takes no new item until the
// sequencer has left its done state and is back in idle, so items never overlap.
// when the receiver stalls, the finished result stays in the output register
// and the sequencer waits in its done state until that register frees up.
// reset (synchronous, active low) empties the output register and returns the
// sequencer to idle; no item is taken while reset is asserted.
module texture_mip_chain_size_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_dimension_3d,
    input  logic                             i_block_compressed,
    input  logic [tmcs_pkg::ESIZE_W-1:0]     i_element_size,
    input  logic [tmcs_pkg::DIM_W-1:0]       i_width,
    input  logic [tmcs_pkg::DIM_W-1:0]       i_height,
    input  logic [tmcs_pkg::LAYER_W-1:0]     i_layers,
    input  logic [tmcs_pkg::MIP_W-1:0]       i_mip_request,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tmcs_pkg::STAT_W-1:0]      o_status,
    output logic [tmcs_pkg::MIP_W-1:0]       o_mip_count,
    output logic [tmcs_pkg::BYTES_W-1:0]     o_total_bytes,
    output logic [tmcs_pkg::IMG_W-1:0]       o_image_count
);
    import tmcs_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;  // row pitch product
    localparam logic [2:0] S_M2   = 3'd2;  // slice pitch product
    localparam logic [2:0] S_M3   = 3'd3;  // slice bytes times count
    localparam logic [2:0] S_ACC  = 3'd4;  // accumulate and halve
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         r_state, n_state;
    logic               r_out_valid, n_out_valid;

    // working registers of the current item
    logic               r_bc, n_bc;
    logic               r_vol, n_vol;
    logic [ESIZE_W-1:0] r_esize, n_esize;
    logic [DIM_W-1:0]   r_w, n_w;
    logic [DIM_W-1:0]   r_h, n_h;
    logic [LAYER_W-1:0] r_cnt, n_cnt;
    logic [MIP_W-1:0]   r_left, n_left;
    logic [MIP_W-1:0]   r_mips, n_mips;
    t_status            r_stat, n_stat;
    logic [BYTES_W-1:0] r_total, n_total;
    logic [IMG_W-1:0]   r_images, n_images;

    // output register
    t_status            r_o_stat, n_o_stat;
    logic [MIP_W-1:0]   r_o_mips, n_o_mips;
    logic [BYTES_W-1:0] r_o_total, n_o_total;
    logic [IMG_W-1:0]   r_o_images, n_o_images;

    logic               in_acc;
    logic               bad_arg;
    logic [MIP_W-1:0]   full_len;
    logic [MIP_W-1:0]   req_mips;
    logic               too_many;

    t_mul_a             mul_a;
    t_mul_b             mul_b;
    t_prod              prod;

    logic [DIM_W:0]     w_p3, h_p3;
    logic [22:0]        row_p7;
    t_mul_a             row;
    logic [MUL_P_W:0]   total_sum;
    logic [IMG_W:0]     img_sum;
    logic               out_free;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_status      = r_o_stat;
    assign o_mip_count   = r_o_mips;
    assign o_total_bytes = r_o_total;
    assign o_image_count = r_o_images;

    // request checks, decided at the input
    assign bad_arg = (i_element_size == '0) || (32'(i_element_size) > MAX_ELEMENT) ||
                     (i_width == '0) || (i_height == '0) || (i_layers == '0) ||
                     (32'(i_width) > MAX_DIMENSION) || (32'(i_height) > MAX_DIMENSION) ||
                     (32'(i_layers) > MAX_LAYERS);
    assign full_len = chain_len(i_width | i_height);
    assign too_many = (i_mip_request > MIP_W'(1)) && (i_mip_request > full_len);
    assign req_mips = (i_mip_request == '0) ? full_len : i_mip_request;

    // 4x4 block counts, and rounding of bit rows up to bytes
    assign w_p3   = {1'b0, r_w} + (DIM_W+1)'(3);
    assign h_p3   = {1'b0, r_h} + (DIM_W+1)'(3);
    assign row_p7 = prod[22:0] + 23'd7;
    assign row    = r_bc ? prod[MUL_A_W-1:0] : MUL_A_W'(row_p7[22:3]);

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1: begin
                mul_a = r_bc ? MUL_A_W'(w_p3[DIM_W:2]) : MUL_A_W'(r_w);
                mul_b = MUL_B_W'(r_esize);
            end
            S_M2: begin
                mul_a = row;
                mul_b = r_bc ? MUL_B_W'(h_p3[DIM_W:2]) : MUL_B_W'(r_h);
            end
            S_M3: begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(r_cnt);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tmcs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign total_sum = (MUL_P_W+1)'(r_total) + (MUL_P_W+1)'(prod);
    assign img_sum   = (IMG_W+1)'(r_images) + (IMG_W+1)'(r_cnt);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_bc        = r_bc;
        n_vol       = r_vol;
        n_esize     = r_esize;
        n_w         = r_w;
        n_h         = r_h;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_mips      = r_mips;
        n_stat      = r_stat;
        n_total     = r_total;
        n_images    = r_images;
        n_o_stat    = r_o_stat;
        n_o_mips    = r_o_mips;
        n_o_total   = r_o_total;
        n_o_images  = r_o_images;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_bc     = i_block_compressed;
                    n_vol    = i_dimension_3d;
                    n_esize  = i_element_size;
                    n_w      = i_width;
                    n_h      = i_height;
                    n_cnt    = i_layers;
                    n_left   = req_mips;
                    n_mips   = req_mips;
                    n_total  = '0;
                    n_images = '0;
                    if (bad_arg) begin
                        n_stat  = ST_BADARG;
                        n_mips  = '0;
                        n_state = S_DONE;
                    end else if (too_many) begin
                        n_stat  = ST_MIPS;
                        n_mips  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_stat  = ST_OK;
                        n_state = S_M1;
                    end
                end
            end
            S_M1: begin
                n_state = S_M2;
            end
            S_M2: begin
                n_state = S_M3;
            end
            S_M3: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                // sums saturate instead of wrapping
                if (total_sum > (MUL_P_W+1)'(BYTES_LIMIT)) begin
                    n_total = BYTES_LIMIT;
                end else begin
                    n_total = total_sum[BYTES_W-1:0];
                end
                if (img_sum > (IMG_W+1)'(IMAGES_LIMIT)) begin
                    n_images = IMAGES_LIMIT;
                end else begin
                    n_images = img_sum[IMG_W-1:0];
                end
                if (r_w > DIM_W'(1)) begin
                    n_w = r_w >> 1;
                end
                if (r_h > DIM_W'(1)) begin
                    n_h = r_h >> 1;
                end
                // volume depth shrinks with the level, array layers do not
                if (r_vol && (r_cnt > LAYER_W'(1))) begin
                    n_cnt = r_cnt >> 1;
                end
                n_left = r_left - MIP_W'(1);
                if (r_left == MIP_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_M1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_stat    = r_stat;
                    n_o_mips    = r_mips;
                    n_o_total   = r_total;
                    n_o_images  = r_images;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bc       <= n_bc;
        r_vol      <= n_vol;
        r_esize    <= n_esize;
        r_w        <= n_w;
        r_h        <= n_h;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_mips     <= n_mips;
        r_stat     <= n_stat;
        r_total    <= n_total;
        r_images   <= n_images;
        r_o_stat   <= n_o_stat;
        r_o_mips   <= n_o_mips;
        r_o_total  <= n_o_total;
        r_o_images <= n_o_images;
    end

    // a rejected item goes straight to the result
    a_reject_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && bad_arg |=> r_state == S_DONE && r_stat == ST_BADARG)
        else $error("rejected item did not go to done");

    // an error result carries no size
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_mip_count == '0 && o_total_bytes == '0 && o_image_count == '0)
        else $error("error result with nonzero fields");

    // a level pass never starts with no levels left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_M1 |-> r_left != '0)
        else $error("level pass with zero levels left");

    // the product passes run in order
    a_pass_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_M1 |=> r_state == S_M2 ##1 r_state == S_M3 ##1 r_state == S_ACC)
        else $error("multiplier passes out of order");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_total_bytes))
        else $error("stalled result lost");

endmodule

### dv/tb_texture_mip_chain_size_top.sv
`timescale 1ns / 100ps

module tb_texture_mip_chain_size_top;

    import tmcs_pkg::*;

    // highest mip count the result field can carry
    localparam int MIPS_CAP = (1 << MIP_W) - 1;

    // one texture description as it crosses the input channel
    typedef struct packed {
        logic               dim3d;
        logic               bc;
        logic [ESIZE_W-1:0] esize;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [LAYER_W-1:0] layers;
        logic [MIP_W-1:0]   mip_request;
    } t_tex_req;

    // one size result as it crosses the output channel
    typedef struct packed {
        t_status            status;
        logic [MIP_W-1:0]   mips;
        logic [BYTES_W-1:0] bytes;
        logic [IMG_W-1:0]   images;
    } t_chain_size;

    // receiver stall patterns
    typedef enum int {FLOW_FREE, FLOW_HALF, FLOW_PERIODIC, FLOW_HEAVY} t_flow_mode;

    // holds the sizes still owed by the block, oldest first
    class chain_size_board;
        t_chain_size expected_sizes[$];
        int unsigned fault_count;

        function new();
            fault_count = 0;
        endfunction

        // byte size and surface count of the requested mip levels, or an error status
        function t_chain_size predict_size(t_tex_req r);
            t_chain_size s;
            longint unsigned w, h, d, full, levels, total, images, slice, count, bw, bh;
            s = '0;
            if (r.esize == 0 || r.esize > MAX_ELEMENT || r.width == 0 || r.height == 0 ||
                r.layers == 0 || r.width > MAX_DIMENSION || r.height > MAX_DIMENSION ||
                r.layers > MAX_LAYERS) begin
                s.status = ST_BADARG;
                return s;
            end
            w = r.width;
            h = r.height;
            full = 1;
            while (w > 1 || h > 1) begin
                if (w > 1) w >>= 1;
                if (h > 1) h >>= 1;
                full++;
            end
            if (r.mip_request == 0) begin
                levels = (full > MIPS_CAP) ? MIPS_CAP : full;
            end else if (r.mip_request == 1) begin
                levels = 1;
            end else if (r.mip_request > full) begin
                s.status = ST_MIPS;
                return s;
            end else begin
                levels = r.mip_request;
            end
            w = r.width;
            h = r.height;
            d = r.dim3d ? r.layers : 1;
            total = 0;
            images = 0;
            for (longint unsigned lvl = 0; lvl < levels; lvl++) begin
                count = r.dim3d ? d : r.layers;
                if (r.bc) begin
                    bw = (w + 3) / 4;
                    bh = (h + 3) / 4;
                    if (bw < 1) bw = 1;
                    if (bh < 1) bh = 1;
                    slice = bw * r.esize * bh;
                end else begin
                    slice = ((w * r.esize + 7) / 8) * h;
                end
                total += slice * count;
                if (total > BYTES_LIMIT) total = BYTES_LIMIT;
                images += count;
                if (images > IMAGES_LIMIT) images = IMAGES_LIMIT;
                if (w > 1) w >>= 1;
                if (h > 1) h >>= 1;
                if (d > 1) d >>= 1;
            end
            s.status = ST_OK;
            s.mips   = MIP_W'(levels);
            s.bytes  = BYTES_W'(total);
            s.images = IMG_W'(images);
            return s;
        endfunction

        function void note_request(t_tex_req r);
            expected_sizes.push_back(predict_size(r));
        endfunction

        function void report_fault(string what, t_chain_size want, t_chain_size got);
            fault_count++;
            if (fault_count <= 10)
                $display("%0t %s: expected status %0d mips %0d bytes %0d images %0d, %s",
                         $time, what, want.status, want.mips, want.bytes, want.images,
                         $sformatf("got status %0d mips %0d bytes %0d images %0d",
                                   got.status, got.mips, got.bytes, got.images));
        endfunction

        function void check_result(t_chain_size got);
            t_chain_size want;
            if (expected_sizes.size() == 0) begin
                report_fault("result with no request pending", '0, got);
                return;
            end
            want = expected_sizes.pop_front();
            if (got.status !== want.status || got.mips !== want.mips ||
                got.bytes !== want.bytes || got.images !== want.images)
                report_fault("size mismatch", want, got);
        endfunction

        function int unsigned pending();
            return expected_sizes.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_dimension_3d;
    logic                i_block_compressed;
    logic [ESIZE_W-1:0]  i_element_size;
    logic [DIM_W-1:0]    i_width;
    logic [DIM_W-1:0]    i_height;
    logic [LAYER_W-1:0]  i_layers;
    logic [MIP_W-1:0]    i_mip_request;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STAT_W-1:0]   o_status;
    logic [MIP_W-1:0]    o_mip_count;
    logic [BYTES_W-1:0]  o_total_bytes;
    logic [IMG_W-1:0]    o_image_count;

    // long receiver hold-off, raised by its own process
    logic                hold_output;

    chain_size_board     board = new();
    int unsigned         accepted_count = 0;
    int unsigned         burst_left = 0;

    texture_mip_chain_size_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_dimension_3d     (i_dimension_3d),
        .i_block_compressed (i_block_compressed),
        .i_element_size     (i_element_size),
        .i_width            (i_width),
        .i_height           (i_height),
        .i_layers           (i_layers),
        .i_mip_request      (i_mip_request),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_mip_count        (o_mip_count),
        .o_total_bytes      (o_total_bytes),
        .o_image_count      (o_image_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_tex_req make_req(int d3, int bc, int esize, int w, int h,
                                          int layers, int req);
        t_tex_req r;
        r.dim3d       = d3[0];
        r.bc          = bc[0];
        r.esize       = ESIZE_W'(esize);
        r.width       = DIM_W'(w);
        r.height      = DIM_W'(h);
        r.layers      = LAYER_W'(layers);
        r.mip_request = MIP_W'(req);
        return r;
    endfunction

    // base dimension: mostly small, some powers of two, some anywhere up to the max
    function automatic int unsigned rand_dim();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 16);
            1: return $urandom_range(1, 512);
            2: return 1 << $urandom_range(0, 14);
            default: return $urandom_range(1, MAX_DIMENSION);
        endcase
    endfunction

    // mostly well-formed textures with random content, a few with one field broken, the rest raw noise
    function automatic t_tex_req random_request();
        t_tex_req r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // raw noise on every bit, mostly rejected
            r.dim3d       = 1'($urandom);
            r.bc          = 1'($urandom);
            r.esize       = ESIZE_W'($urandom);
            r.width       = DIM_W'($urandom);
            r.height      = DIM_W'($urandom);
            r.layers      = LAYER_W'($urandom);
            r.mip_request = MIP_W'($urandom);
            return r;
        end
        r.dim3d  = 1'($urandom);
        r.bc     = 1'($urandom);
        r.width  = DIM_W'(rand_dim());
        r.height = DIM_W'(rand_dim());
        case ($urandom_range(0, 2))
            0: r.layers = LAYER_W'($urandom_range(1, 8));
            1: r.layers = LAYER_W'(1 << $urandom_range(0, 11));
            default: r.layers = LAYER_W'($urandom_range(1, MAX_LAYERS));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            r.esize = ESIZE_W'($urandom_range(1, MAX_ELEMENT));
        end else if (r.bc) begin
            r.esize = $urandom_range(0, 1) ? ESIZE_W'(8) : ESIZE_W'(16);
        end else begin
            r.esize = ESIZE_W'(8 << $urandom_range(0, 4));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.mip_request = '0;
            5: r.mip_request = MIP_W'(1);
            default: r.mip_request = MIP_W'($urandom_range(2, MIPS_CAP));
        endcase
        // occasionally break one field of an otherwise good texture
        if (pick >= 96) begin
            case ($urandom_range(0, 3))
                0: r.esize = $urandom_range(0, 1) ? '0 : ESIZE_W'($urandom_range(129, 255));
                1: r.width = DIM_W'($urandom_range(MAX_DIMENSION + 1, (1 << DIM_W) - 1));
                2: r.height = '0;
                default: r.layers = LAYER_W'($urandom_range(MAX_LAYERS + 1, (1 << LAYER_W) - 1));
            endcase
        end
        return r;
    endfunction

    // offer one item, with bursts and random gaps between them
    task automatic offer_item(input t_tex_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid         <= 1'b1;
        i_dimension_3d     <= r.dim3d;
        i_block_compressed <= r.bc;
        i_element_size     <= r.esize;
        i_width            <= r.width;
        i_height           <= r.height;
        i_layers           <= r.layers;
        i_mip_request      <= r.mip_request;
        // payload stays put until the block takes it
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(r);
        accepted_count++;
    endtask

    // receiver: checks every taken result and stalls on changing patterns
    initial begin
        t_chain_size got;
        t_flow_mode  mode;
        int unsigned left;
        logic        stall_now;
        i_out_stall <= 1'b0;
        mode = FLOW_FREE;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.status = o_status;
                got.mips   = o_mip_count;
                got.bytes  = o_total_bytes;
                got.images = o_image_count;
                board.check_result(got);
            end
            if (left == 0) begin
                mode = t_flow_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                FLOW_FREE:     stall_now = 1'b0;
                FLOW_HALF:     stall_now = 1'($urandom_range(0, 1));
                FLOW_PERIODIC: stall_now = (left % 4) == 0;
                default:       stall_now = $urandom_range(0, 9) != 0;
            endcase
            i_out_stall <= hold_output || stall_now;
        end
    end

    // long hold-off on the output so the block backs up into its input
    initial begin
        hold_output <= 1'b0;
        for (int k = 1; k <= 2; k++) begin
            wait (accepted_count >= k * 700);
            @(posedge i_clk);
            hold_output <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_output <= 1'b0;
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_dimension_3d     <= 1'b0;
        i_block_compressed <= 1'b0;
        i_element_size     <= '0;
        i_width            <= '0;
        i_height           <= '0;
        i_layers           <= '0;
        i_mip_request      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest texture, then the largest array and volume over a full chain
        offer_item(make_req(0, 0, 1, 1, 1, 1, 0));
        offer_item(make_req(0, 0, 128, 16384, 16384, 2048, 0));
        offer_item(make_req(1, 0, 128, 16384, 16384, 2048, 0));
        // compressed volume at the max with exactly the chain length requested
        offer_item(make_req(1, 1, 16, 16384, 16384, 2048, 15));
        // compressed level smaller than one block, odd block sizes
        offer_item(make_req(0, 1, 8, 1, 1, 1, 0));
        offer_item(make_req(0, 1, 3, 5, 7, 3, 0));
        offer_item(make_req(0, 1, 128, 13, 2, 1, 0));
        // row pitch rounding with one-bit and 24-bit pixels
        offer_item(make_req(0, 0, 1, 3, 1, 1, 0));
        offer_item(make_req(0, 0, 24, 3, 1000, 5, 1));
        // too many mips, one past the chain, exactly the chain
        offer_item(make_req(0, 0, 32, 8, 8, 1, 15));
        offer_item(make_req(0, 0, 32, 4, 1, 1, 4));
        offer_item(make_req(0, 0, 32, 4, 1, 1, 3));
        offer_item(make_req(0, 0, 8, 1, 1, 1, 2));
        // deep volume whose depth outlives the chain
        offer_item(make_req(1, 0, 8, 2, 2, 2048, 0));
        // undefined and oversized element sizes
        offer_item(make_req(0, 0, 0, 16, 16, 1, 0));
        offer_item(make_req(0, 0, 129, 16, 16, 1, 0));
        offer_item(make_req(0, 1, 255, 16, 16, 1, 0));
        // zero and oversized dimensions and layer counts
        offer_item(make_req(0, 0, 8, 0, 16, 1, 0));
        offer_item(make_req(0, 0, 8, 16, 0, 1, 0));
        offer_item(make_req(0, 0, 8, 16, 16, 0, 0));
        offer_item(make_req(0, 0, 8, 16385, 16, 1, 0));
        offer_item(make_req(0, 0, 8, 16, 16385, 1, 0));
        offer_item(make_req(1, 0, 8, 16, 16, 2049, 0));
        offer_item(make_req(1, 1, 255, 32767, 32767, 4095, 15));

        repeat (1900) offer_item(random_request());
        i_in_valid <= 1'b0;

        // drain, then leave room for any stray result
        while (board.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (board.fault_count == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### texture_mip_chain_size_top.f
rtl/tmcs_pkg.sv
rtl/tmcs_mul.sv
rtl/texture_mip_chain_size_top.sv
dv/tb_texture_mip_chain_size_top.sv
